>>> sv/grwf_pkg.sv
package grwf_pkg;

  localparam int CELL_SHIFT = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef enum logic [1:0] {
    ST_WALL  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_OUT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

endpackage

>>> sv/grid_ray_wall_finder.sv
// Grid ray wall finder.
// Input channel (in_*): in_tuser = 0 writes one map cell, in_tuser = 1 casts a ray
// from a fixed-point position (2048 units per cell) along a small signed direction.
// Output channel (out_*): one result per cast, none per write: ending cell, its
// wall code, the axis of the last step and why the walk stopped (wall, step
// limit, left the grid).
// The map sits in a single-port-write, registered-read memory of GRID_SIZE^2
// four-bit cells. The walk issues one read per visited cell; a cast whose start
// cell lies outside the grid reads no cell. Items are taken one at a time;
// in_tready is high only while the block is idle.
// After reset the block clears all GRID_SIZE^2 cells of the map (1024 at the
// default size), one cell per cycle; in_tready stays low during that pass.
// The result is held in an output register; while the receiver stalls, the
// block keeps it and a finished cast waits before the next input is taken.
module grid_ray_wall_finder #(
  parameter int GRID_SIZE = 32,
  parameter int MAX_STEPS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[15:0], pos_y[31:16], dir_x[39:32], dir_y[47:40], cell_col[52:48],
  // cell_row[57:53], cell_code[61:58], zero pad[63:62]
  input  logic [63:0] in_tdata,
  // cmd[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // hit_side[0], hit_col[5:1], hit_row[10:6], wall_code[14:11], status[16:15],
  // zero pad[23:17]
  output logic [23:0] out_tdata
);

  import grwf_pkg::*;

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIZE);
  localparam int CW    = $clog2((GRID_SIZE > 32) ? GRID_SIZE : 32) + 2;
  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int EW    = 10;

  function automatic logic in_grid(logic signed [CW-1:0] c, logic signed [CW-1:0] r);
    logic signed [CW-1:0] g;
    g = $signed(CW'(GRID_SIZE));
    return !c[CW-1] && !r[CW-1] && (c < g) && (r < g);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] c,
                                              logic signed [CW-1:0] r);
    return AW'(AW'(r[IW-1:0]) * AW'(GRID_SIZE)) + AW'(c[IW-1:0]);
  endfunction

  // input fields
  logic [15:0] pos_x, pos_y;
  logic [7:0]  dir_x, dir_y;
  logic [4:0]  cell_col, cell_row;
  logic [3:0]  cell_code;

  assign pos_x     = in_tdata[15:0];
  assign pos_y     = in_tdata[31:16];
  assign dir_x     = in_tdata[39:32];
  assign dir_y     = in_tdata[47:40];
  assign cell_col  = in_tdata[52:48];
  assign cell_row  = in_tdata[57:53];
  assign cell_code = in_tdata[61:58];

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic signed [CW-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic [7:0]            major_r, major_nxt, minor_r, minor_nxt;
  logic                  swap_r, swap_nxt, neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [SW-1:0]         step_cnt_r, step_cnt_nxt;
  logic                  side_r, side_nxt;
  logic [3:0]            code_r, code_nxt;
  status_t               status_r, status_nxt;
  logic                  out_tvalid_r;
  logic [23:0]           out_tdata_r;

  // map memory
  logic [3:0]    wall_mem [DEPTH];
  logic [3:0]    rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [3:0]    mem_wdata;

  // combinational helpers
  logic                 accept, out_load, free_slot;
  logic signed [CW-1:0] st_col, st_row, col_step, row_step;
  logic [8:0]           ax9, ay9;
  logic [7:0]           ax, ay;
  logic signed [EW-1:0] e1;
  logic                 take_minor, move_row;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign free_slot = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_DONE) && free_slot;

  always_comb begin
    st_col = $signed(CW'(pos_x[15:CELL_SHIFT]));
    st_row = $signed(CW'(pos_y[15:CELL_SHIFT]));
    ax9    = dir_x[7] ? (9'd0 - {dir_x[7], dir_x}) : {1'b0, dir_x};
    ay9    = dir_y[7] ? (9'd0 - {dir_y[7], dir_y}) : {1'b0, dir_y};
    ax     = ax9[7:0];
    ay     = ay9[7:0];

    e1         = err_r + $signed({2'b00, minor_r});
    take_minor = (e1 > $signed(EW'(0)));
    move_row   = swap_r ? !take_minor : take_minor;
    col_step   = col_r;
    row_step   = row_r;
    if (move_row) begin
      row_step = neg_y_r ? (row_r - $signed(CW'(1))) : (row_r + $signed(CW'(1)));
    end else begin
      col_step = neg_x_r ? (col_r - $signed(CW'(1))) : (col_r + $signed(CW'(1)));
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    err_nxt      = err_r;
    major_nxt    = major_r;
    minor_nxt    = minor_r;
    swap_nxt     = swap_r;
    neg_x_nxt    = neg_x_r;
    neg_y_nxt    = neg_y_r;
    step_cnt_nxt = step_cnt_r;
    side_nxt     = side_r;
    code_nxt     = code_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_waddr    = clr_cnt_r;
    mem_wdata    = 4'd0;
    mem_re       = 1'b0;
    mem_raddr    = cell_addr(col_step, row_step);

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_WRITE) begin
            mem_we    = in_grid($signed(CW'(cell_col)), $signed(CW'(cell_row)));
            mem_waddr = cell_addr($signed(CW'(cell_col)), $signed(CW'(cell_row)));
            mem_wdata = cell_code;
          end else begin
            col_nxt      = st_col;
            row_nxt      = st_row;
            swap_nxt     = (ay > ax);
            major_nxt    = (ay > ax) ? ay : ax;
            minor_nxt    = (ay > ax) ? ax : ay;
            err_nxt      = -$signed({2'b00, ((ay > ax) ? ay : ax)});
            neg_x_nxt    = dir_x[7];
            neg_y_nxt    = dir_y[7];
            step_cnt_nxt = '0;
            side_nxt     = 1'b1;
            code_nxt     = 4'd0;
            if (in_grid(st_col, st_row)) begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(st_col, st_row);
              state_nxt = S_WALK;
            end else begin
              status_nxt = ST_OUT;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_WALK: begin
        if (rd_data_r != 4'd0) begin
          code_nxt   = rd_data_r;
          status_nxt = ST_WALL;
          state_nxt  = S_DONE;
        end else if (step_cnt_r >= SW'(MAX_STEPS)) begin
          code_nxt   = 4'd0;
          status_nxt = ST_LIMIT;
          state_nxt  = S_DONE;
        end else begin
          step_cnt_nxt = step_cnt_r + SW'(1);
          err_nxt      = take_minor ? (e1 - $signed({2'b00, major_r})) : e1;
          col_nxt      = col_step;
          row_nxt      = row_step;
          side_nxt     = move_row;
          if (in_grid(col_step, row_step)) begin
            mem_re = 1'b1;
          end else begin
            code_nxt   = 4'd0;
            status_nxt = ST_OUT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (free_slot) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wall_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= wall_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      step_cnt_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      step_cnt_r <= step_cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    err_r    <= err_nxt;
    major_r  <= major_nxt;
    minor_r  <= minor_nxt;
    swap_r   <= swap_nxt;
    neg_x_r  <= neg_x_nxt;
    neg_y_r  <= neg_y_nxt;
    side_r   <= side_nxt;
    code_r   <= code_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_tdata_r <= {7'd0, status_r, code_r, row_r[4:0], col_r[4:0], side_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished walk");

  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken during map clear");

  a_wall_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[16:15] == ST_WALL) |-> (out_tdata_r[14:11] != 4'd0))
    else $error("wall status with empty code");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[16:15] == ST_WALL || out_tdata_r[16:15] == ST_LIMIT ||
                      out_tdata_r[16:15] == ST_OUT))
    else $error("illegal status code");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (step_cnt_r <= SW'(MAX_STEPS)))
    else $error("step counter past limit");

endmodule
